FILE: sv/fpfl_pkg.sv
`timescale 1ns / 1ps

package fpfl_pkg;

  localparam int POOL_SLOTS = 1024;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int STRIDE_W   = 16;
  localparam int SIZE_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int FUNC_W     = 2;
  localparam int OFS_W      = SLOT_W + STRIDE_W;
  localparam int DIV_CNT_W  = $clog2(SLOT_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // end-of-list marker for the link memory and the free head
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE  = 2'd3;

  localparam logic [SIZE_W-1:0]   SIZE_LIMIT_RESET = 16'd64;
  localparam logic [ADDR_W-1:0]   BASE_RESET       = '0;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET     = 16'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_FREE_CHK,
    ST_FREE_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: sv/fpfl_link_mem.sv
`timescale 1ns / 1ps

module fpfl_link_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [fpfl_pkg::SLOT_W-1:0] wr_addr,
  input  logic [fpfl_pkg::LINK_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [fpfl_pkg::SLOT_W-1:0] rd_addr,
  output logic [fpfl_pkg::LINK_W-1:0] rd_data
);
  import fpfl_pkg::*;

  logic [LINK_W-1:0] mem [POOL_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/fpfl_slot_div.sv
`timescale 1ns / 1ps

module fpfl_slot_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fpfl_pkg::OFS_W-1:0]    dividend,
  input  logic [fpfl_pkg::STRIDE_W-1:0] divisor,
  output logic                          done,
  output logic [fpfl_pkg::SLOT_W-1:0]   quotient
);
  import fpfl_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [OFS_W-1:0]     rem;
  logic [OFS_W-1:0]     dsr;
  logic                 ge;

  // dividend is known to be below POOL_SLOTS * divisor, so one quotient bit per step
  assign ge = rem >= dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SLOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsr      <= OFS_W'(divisor) << (SLOT_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsr;
      end
      dsr      <= dsr >> 1;
      quotient <= {quotient[SLOT_W-2:0], ge};
    end
  end

endmodule

FILE: sv/fixed_pool_free_list_allocator_top.sv
`timescale 1ns / 1ps
// allocate: IDLE, then ALLOC_RD, where the read of the link memory at the head gives the new head
// free: FREE_CHK, then FREE_DIV with the bit-per-cycle slot index divider (10 steps)
// release, unused code and rejected allocates finish in IDLE; rejected frees finish in FREE_CHK
// output register lets a new request enter while the previous result waits
// synchronous reset: config to defaults, pool dropped; link memory is not cleared

module fixed_pool_free_list_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fpfl_pkg::FUNC_W-1:0]     func,
  input  logic [fpfl_pkg::SIZE_W-1:0]     request_size,
  input  logic [fpfl_pkg::ADDR_W-1:0]     address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fpfl_pkg::ADDR_W-1:0]     granted_address,
  output logic                            source,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpfl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpfl_pkg::*;

  state_t state, state_next;

  logic                pool_enable;
  logic [SIZE_W-1:0]   size_limit;
  logic [ADDR_W-1:0]   base_address;
  logic [STRIDE_W-1:0] slot_stride;
  logic [STRIDE_W-1:0] step;
  logic [OFS_W-1:0]    span;

  logic                pool_made, pool_made_next;
  logic [LINK_W-1:0]   free_head, free_head_next;
  logic [LINK_W-1:0]   fresh_count, fresh_count_next;
  logic                pop, pop_next;
  logic [OFS_W-1:0]    product, product_next;
  logic [ADDR_W:0]     offset, offset_next;
  logic                free_ok, free_ok_next;
  logic [ADDR_W-1:0]   res_addr, res_addr_next;
  logic                res_src, res_src_next;
  logic                out_valid_next;
  logic [ADDR_W-1:0]   granted_address_next;
  logic                source_next;

  logic                alloc_ok;
  logic [LINK_W-1:0]   head_eff;
  logic [LINK_W-1:0]   fresh_eff;
  logic [LINK_W-1:0]   fresh_first;
  logic                head_ok;
  logic                slot_avail;
  logic [SLOT_W-1:0]   slot_sel;
  logic                range_ok;
  logic                out_free;

  logic                fin;
  logic [ADDR_W-1:0]   fin_addr;
  logic                fin_src;

  logic                rd_en;
  logic [LINK_W-1:0]   rd_data;
  logic                wr_en;
  logic                div_start;
  logic                div_done;
  logic [SLOT_W-1:0]   quotient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_enable  <= 1'b1;
      size_limit   <= SIZE_LIMIT_RESET;
      base_address <= BASE_RESET;
      slot_stride  <= STRIDE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POOL_ENABLE:  pool_enable  <= cfg_data[0];
        CFG_SIZE_LIMIT:   size_limit   <= cfg_data[SIZE_W-1:0];
        CFG_BASE_ADDRESS: base_address <= cfg_data[ADDR_W-1:0];
        CFG_SLOT_STRIDE:  slot_stride  <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero stride behaves as one byte
  assign step = (slot_stride == '0) ? STRIDE_W'(1) : slot_stride;

  // offset of the last slot, refreshed every cycle from the config
  always_ff @(posedge clk) begin
    span <= OFS_W'(step) * OFS_W'(POOL_SLOTS - 1);
  end

  // a pool not yet made looks freshly built
  assign alloc_ok    = pool_enable && (request_size <= size_limit);
  assign head_eff    = pool_made ? free_head : NULL_LINK;
  assign fresh_eff   = pool_made ? fresh_count : LINK_W'(POOL_SLOTS);
  assign fresh_first = NULL_LINK - fresh_eff;
  assign head_ok     = head_eff < NULL_LINK;
  assign slot_avail  = head_ok || (fresh_eff != '0);
  assign slot_sel    = head_ok ? head_eff[SLOT_W-1:0] : fresh_first[SLOT_W-1:0];
  assign range_ok    = free_ok && !offset[ADDR_W] && (offset[ADDR_W-1:0] <= ADDR_W'(span));
  assign out_free    = !out_valid || out_ready;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_FREE) begin
            state_next = ST_FREE_CHK;
          end else if (func == FUNC_ALLOC && alloc_ok && slot_avail) begin
            state_next = ST_ALLOC_RD;
          end else if (!out_free) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_ALLOC_RD: begin
        state_next = out_free ? ST_IDLE : ST_DONE;
      end
      ST_FREE_CHK: begin
        if (range_ok) begin
          state_next = ST_FREE_DIV;
        end else begin
          state_next = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_FREE_DIV: begin
        if (div_done) begin
          state_next = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pool_made_next       = pool_made;
    free_head_next       = free_head;
    fresh_count_next     = fresh_count;
    pop_next             = pop;
    product_next         = product;
    offset_next          = offset;
    free_ok_next         = free_ok;
    res_addr_next        = res_addr;
    res_src_next         = res_src;
    out_valid_next       = out_valid && !out_ready;
    granted_address_next = granted_address;
    source_next          = source;
    fin                  = 1'b0;
    fin_addr             = '0;
    fin_src              = 1'b0;
    rd_en                = 1'b0;
    wr_en                = 1'b0;
    div_start            = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_ALLOC: begin
              if (alloc_ok) begin
                pool_made_next   = 1'b1;
                free_head_next   = head_eff;
                fresh_count_next = fresh_eff;
                pop_next         = head_ok;
                rd_en            = head_ok;
                product_next     = OFS_W'(slot_sel) * OFS_W'(step);
                if (!head_ok) begin
                  if (fresh_eff != '0) begin
                    fresh_count_next = fresh_eff - 1'b1;
                  end else begin
                    fin     = 1'b1;
                    fin_src = 1'b1;
                  end
                end
              end else begin
                fin     = 1'b1;
                fin_src = 1'b1;
              end
            end
            FUNC_FREE: begin
              offset_next  = {1'b0, address} - {1'b0, base_address};
              free_ok_next = pool_enable && pool_made;
            end
            FUNC_RELEASE: begin
              pool_made_next   = 1'b0;
              free_head_next   = NULL_LINK;
              fresh_count_next = '0;
              fin              = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_ALLOC_RD: begin
        if (pop) begin
          free_head_next = rd_data;
        end
        fin      = 1'b1;
        fin_addr = base_address + ADDR_W'(product);
      end
      ST_FREE_CHK: begin
        if (range_ok) begin
          div_start = 1'b1;
        end else begin
          fin     = 1'b1;
          fin_src = 1'b1;
        end
      end
      ST_FREE_DIV: begin
        if (div_done) begin
          wr_en          = 1'b1;
          free_head_next = {1'b0, quotient};
          fin            = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_next       = 1'b1;
          granted_address_next = res_addr;
          source_next          = res_src;
        end
      end
      default: ;
    endcase

    // result goes straight to the output register when it is free, else parks
    if (fin) begin
      if (out_free) begin
        out_valid_next       = 1'b1;
        granted_address_next = fin_addr;
        source_next          = fin_src;
      end else begin
        res_addr_next = fin_addr;
        res_src_next  = fin_src;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pool_made   <= 1'b0;
      free_head   <= NULL_LINK;
      fresh_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      pool_made   <= pool_made_next;
      free_head   <= free_head_next;
      fresh_count <= fresh_count_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pop             <= pop_next;
    product         <= product_next;
    offset          <= offset_next;
    free_ok         <= free_ok_next;
    res_addr        <= res_addr_next;
    res_src         <= res_src_next;
    granted_address <= granted_address_next;
    source          <= source_next;
  end

  fpfl_link_mem u_link_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (quotient),
    .wr_data (free_head),
    .rd_en   (rd_en),
    .rd_addr (head_eff[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  fpfl_slot_div u_slot_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset[OFS_W-1:0]),
    .divisor  (step),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fpfl_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 40;

  typedef struct packed {
    logic [ADDR_W-1:0] granted;
    logic              src;
  } grant_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [FUNC_W-1:0]     func;
  logic [SIZE_W-1:0]     request_size;
  logic [ADDR_W-1:0]     address;
  logic                  out_valid;
  logic                  out_ready;
  logic [ADDR_W-1:0]     granted_address;
  logic                  source;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fixed_pool_free_list_allocator_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .request_size    (request_size),
    .address         (address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .granted_address (granted_address),
    .source          (source),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // shadow copy of the pool: registers, free list and creation state
  logic                pool_on;
  logic [SIZE_W-1:0]   limit_bytes;
  logic [ADDR_W-1:0]   pool_base;
  logic [STRIDE_W-1:0] stride_bytes;
  logic [LINK_W-1:0]   link_mem [POOL_SLOTS];
  logic [LINK_W-1:0]   free_top;
  logic                pool_exists;
  logic [LINK_W-1:0]   fresh_left;

  grant_t            expected_grants[$];
  logic [ADDR_W-1:0] live_slots[$];

  int send_idle_pct;
  int stall_pct;
  int n_errors;
  int n_sent;
  int n_checked;
  int n_pool;
  int n_general;
  int n_cfg;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] slot_address_of(logic [63:0] slot);
    logic [63:0] step;
    step = (stride_bytes == 0) ? 64'd1 : 64'(stride_bytes);
    return 32'(64'(pool_base) + slot * step);
  endfunction

  // advances the shadow pool by one request and returns the answer it should give
  function automatic grant_t pool_outcome(logic [FUNC_W-1:0] f, logic [SIZE_W-1:0] sz,
                                          logic [ADDR_W-1:0] a);
    grant_t res;
    logic [ADDR_W-1:0] ofs;
    logic [63:0] step;
    logic [63:0] span;
    logic [63:0] slot;
    res = '0;
    step = (stride_bytes == 0) ? 64'd1 : 64'(stride_bytes);
    case (f)
      FUNC_ALLOC: begin
        if (pool_on && sz <= limit_bytes) begin
          if (!pool_exists) begin
            pool_exists = 1'b1;
            free_top = NULL_LINK;
            fresh_left = LINK_W'(POOL_SLOTS);
          end
          if (free_top < POOL_SLOTS) begin
            res.granted = slot_address_of(64'(free_top));
            free_top = link_mem[free_top[SLOT_W-1:0]];
          end else if (fresh_left != 0) begin
            res.granted = slot_address_of(64'(POOL_SLOTS) - 64'(fresh_left));
            fresh_left = fresh_left - 1'b1;
          end else begin
            res.src = 1'b1;
          end
        end else begin
          res.src = 1'b1;
        end
      end
      FUNC_FREE: begin
        ofs = a - pool_base;
        span = 64'(POOL_SLOTS - 1) * step;
        if (pool_on && pool_exists && a >= pool_base && 64'(ofs) <= span) begin
          slot = 64'(ofs) / step;
          if (slot >= POOL_SLOTS) slot = POOL_SLOTS - 1;
          link_mem[slot[SLOT_W-1:0]] = free_top;
          free_top = LINK_W'(slot);
        end else begin
          res.src = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        pool_exists = 1'b0;
        free_top = NULL_LINK;
        fresh_left = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $time, what, got, want);
    n_errors++;
  endtask

  // caller must send again or drain in the same step, or the item would repeat
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [SIZE_W-1:0] sz,
                              input logic [ADDR_W-1:0] a);
    grant_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    request_size <= sz;
    address <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = pool_outcome(f, sz, a);
    expected_grants.push_back(predicted);
    n_sent++;
    if (predicted.src) n_general++;
    else if (f == FUNC_ALLOC) begin
      n_pool++;
      live_slots.push_back(predicted.granted);
    end
    if (f == FUNC_RELEASE) live_slots.delete();
    @(negedge clk);
  endtask

  task automatic wait_drain;
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_POOL_ENABLE:  pool_on = data[0];
      CFG_SIZE_LIMIT:   limit_bytes = data[SIZE_W-1:0];
      CFG_BASE_ADDRESS: pool_base = data[ADDR_W-1:0];
      CFG_SLOT_STRIDE:  stride_bytes = data[STRIDE_W-1:0];
      default: begin
      end
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_pool_config(input logic en, input logic [SIZE_W-1:0] lim,
                                 input logic [ADDR_W-1:0] base, input logic [STRIDE_W-1:0] stride);
    wait_drain();
    cfg_write(CFG_POOL_ENABLE, 32'(en));
    cfg_write(CFG_SIZE_LIMIT, 32'(lim));
    cfg_write(CFG_BASE_ADDRESS, base);
    cfg_write(CFG_SLOT_STRIDE, 32'(stride));
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // default registers: base 0, stride 64, limit 64
  task automatic test_directed;
    set_idling(0, 0);
    send_request(FUNC_FREE, 16'd0, 32'h0000_0040);     // pool not made yet
    send_request(FUNC_ALLOC, 16'd0, 32'd0);            // creates the pool
    send_request(FUNC_ALLOC, 16'd64, 32'd0);           // size at the limit
    send_request(FUNC_ALLOC, 16'd65, 32'd0);           // one over the limit
    send_request(FUNC_ALLOC, 16'hFFFF, 32'd0);
    send_request(FUNC_FREE, 16'd0, 32'h0000_0040);
    send_request(FUNC_FREE, 16'd0, 32'h0000_0040);     // double free
    send_request(FUNC_ALLOC, 16'd1, 32'd0);
    send_request(FUNC_ALLOC, 16'd2, 32'd0);
    send_request(FUNC_FREE, 16'd0, 32'h0000_007F);     // unaligned, snaps to slot 1
    send_request(FUNC_FREE, 16'd0, 32'h0000_FFC0);     // last slot
    send_request(FUNC_FREE, 16'd0, 32'h0000_FFC1);
    send_request(FUNC_FREE, 16'd0, 32'h0001_0000);     // just past the range
    send_request(FUNC_FREE, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 16'd3, 32'd0);
    send_request(FUNC_ALLOC, 16'd4, 32'd0);
    send_request(FUNC_ALLOC, 16'd5, 32'd0);
    send_request(FUNC_ALLOC, 16'd6, 32'd0);            // slot 1 again from the free list
    send_request(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(FUNC_RELEASE, 16'd0, 32'd0);
    send_request(FUNC_FREE, 16'd0, 32'h0000_0080);     // pool dropped
    send_request(FUNC_RELEASE, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 16'd0, 32'd0);            // rebuilt from slot 0
    wait_drain();
  endtask

  task automatic test_register_extremes;
    set_idling(26, 26);
    set_pool_config(1'b0, 16'd64, 32'd0, 16'd64);
    send_request(FUNC_ALLOC, 16'd0, 32'd0);
    send_request(FUNC_FREE, 16'd0, 32'd0);
    // zero stride acts as one, slot 1 wraps to address 0
    set_pool_config(1'b1, 16'd0, 32'hFFFF_FFFF, 16'd0);
    send_request(FUNC_RELEASE, 16'd0, 32'd0);
    send_request(FUNC_ALLOC, 16'd0, 32'd0);
    send_request(FUNC_ALLOC, 16'd1, 32'd0);
    send_request(FUNC_ALLOC, 16'd0, 32'd0);
    send_request(FUNC_FREE, 16'd0, 32'd0);
    send_request(FUNC_FREE, 16'd0, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 16'd0, 32'd0);
    set_pool_config(1'b1, 16'hFFFF, 32'd0, 16'hFFFF);
    send_request(FUNC_RELEASE, 16'd0, 32'd0);
    send_request(FUNC_ALLOC, 16'hFFFF, 32'd0);
    send_request(FUNC_FREE, 16'd0, 32'h03FE_FC01);
    send_request(FUNC_FREE, 16'd0, 32'h03FF_FBFF);
    send_request(FUNC_ALLOC, 16'd7, 32'd0);
    wait_drain();
  endtask

  task automatic test_exhaustion;
    set_idling(26, 26);
    set_pool_config(1'b1, 16'hFFFF, 32'h8000_0000, 16'd16);
    send_request(FUNC_RELEASE, 16'd0, 32'd0);
    repeat (POOL_SLOTS) send_request(FUNC_ALLOC, 16'($urandom), 32'($urandom));
    send_request(FUNC_ALLOC, 16'd0, 32'd0);            // empty pool goes general
    send_request(FUNC_ALLOC, 16'hFFFF, 32'd0);
    send_request(FUNC_FREE, 16'd0, 32'h8000_0010);
    send_request(FUNC_ALLOC, 16'd0, 32'd0);
    send_request(FUNC_ALLOC, 16'd0, 32'd0);
    wait_drain();
  endtask

  task automatic test_random_traffic;
    int phase;
    int k;
    int r;
    int pick;
    logic [FUNC_W-1:0] f;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] step32;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_idling(0, 0);
          set_pool_config(1'b1, 16'd64, 32'h1000_0000, 16'd64);
        end
        1: begin
          set_idling(47, 0);
          set_pool_config(1'b1, 16'hFFFF, 32'($urandom), 16'd1);
        end
        2: begin
          set_idling(0, 47);
          set_pool_config(1'b1, 16'd300, 32'hFFFF_0000, 16'd100);
        end
        default: begin
          set_idling(26, 26);
          set_pool_config(1'b1, 16'($urandom), 32'($urandom), 16'hFFFF);
        end
      endcase
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        r = $urandom_range(99);
        step32 = (stride_bytes == 0) ? 32'd1 : 32'(stride_bytes);
        sz = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, limit_bytes));
        a = $urandom;
        if (r < 45) begin
          f = FUNC_ALLOC;
        end else if (r < 80) begin
          f = FUNC_FREE;
          if (live_slots.size() != 0 && $urandom_range(99) < 85) begin
            pick = $urandom_range(0, live_slots.size() - 1);
            a = live_slots[pick];
            // mostly hand it back once, sometimes keep it for a double free
            if ($urandom_range(99) >= 5) live_slots.delete(pick);
            if ($urandom_range(99) < 30) a = a + $urandom_range(0, step32 - 1);
          end else if ($urandom_range(1) == 0) begin
            a = pool_base + $urandom_range(0, POOL_SLOTS - 1) * step32
                + $urandom_range(0, step32 - 1);
          end
        end else if (r < 95) begin
          f = 2'($urandom);
        end else if (r < 97) begin
          f = FUNC_RELEASE;
        end else begin
          f = FUNC_UNUSED;
        end
        send_request(f, sz, a);
      end
    end
    wait_drain();
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    grant_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("result with no request outstanding", granted_address, '0);
      end else begin
        want = expected_grants.pop_front();
        n_checked++;
        if (granted_address !== want.granted)
          report_mismatch("granted_address", granted_address, want.granted);
        if (source !== want.src)
          report_mismatch("source", 32'(source), 32'(want.src));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_grants.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_ALLOC;
    request_size = '0;
    address = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_POOL_ENABLE;
    cfg_data = '0;
    pool_on = 1'b1;
    limit_bytes = SIZE_LIMIT_RESET;
    pool_base = BASE_RESET;
    stride_bytes = STRIDE_RESET;
    free_top = NULL_LINK;
    pool_exists = 1'b0;
    fresh_left = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_pool = 0;
    n_general = 0;
    n_cfg = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_register_extremes();
    test_exhaustion();
    test_random_traffic();

    wait_drain();
    repeat (20) @(posedge clk);
    if (expected_grants.size() != 0)
      report_mismatch("results never delivered", 32'(expected_grants.size()), '0);
    $display("covered %0d requests and %0d register writes, %0d results checked",
             n_sent, n_cfg, n_checked);
    $display("pool grants %0d, passed to general %0d, pool exhausted and stride extremes included",
             n_pool, n_general);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
